### design/round_robin_sleep_task_selector_assert.svh
// Assertion macros for the round-robin sleep task selector.
// Used by the top level; expects clk and rst in scope.
`ifndef ROUND_ROBIN_SLEEP_TASK_SELECTOR_ASSERT_SVH
`define ROUND_ROBIN_SLEEP_TASK_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RRSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrss assertion failed");

// Next-cycle implication, checked out of reset.
`define RRSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrss assertion failed");

`endif

### design/rrss_pkg.sv
// Package for the round-robin sleep task selector: opcodes, register
// indexes, controller states and fixed widths. No dependencies.
package rrss_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic [DATA_W-1:0] US_PER_MS = 32'd1000;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SLEEP_US = 2'd1,
    OP_SLEEP_MS = 2'd2
  } op_t;

  localparam logic [0:0] REG_TASK_COUNT     = 1'b0;
  localparam logic [0:0] REG_SWITCH_ON_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WAIT,
    ST_SCHED,
    ST_CHECK,
    ST_FIN
  } state_t;

endpackage

### design/rrss_div.sv
// Divider by a constant divisor through reciprocal multiplication.
// Uses rrss_pkg for the data width.
module rrss_div #(
  parameter int unsigned DIVISOR = 10000
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rrss_pkg::DATA_W-1:0]  dividend,
  output logic [rrss_pkg::DATA_W-1:0]  quotient,
  output logic                         done
);

  localparam int DW = rrss_pkg::DATA_W;
  localparam int PW = 2 * DW;
  localparam int L  = $clog2(DIVISOR);
  localparam int SH = DW + L;
  // Rounded-up reciprocal; exact for every dividend below 2^DW.
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [DW-1:0] RECIP_LO = DW'(RECIP);
  localparam logic          RECIP_HI = 1'(RECIP >> DW);

  logic [DW-1:0] x;
  logic [PW-1:0] prod;
  logic [PW:0]   sum;
  logic          pend;

  // Add the top reciprocal bit as a shifted copy of the dividend.
  assign sum = {1'b0, prod} + (RECIP_HI ? {1'b0, x, {DW{1'b0}}} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= start;
      if (pend) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= dividend;
      prod <= PW'(dividend) * PW'(RECIP_LO);
    end
    if (pend) begin
      quotient <= DW'(sum >> SH);
    end
  end

endmodule

### design/rrss_wake_mem.sv
// Wake-tick store: one-port-read, one-port-write memory with registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses rrss_pkg.
module rrss_wake_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [rrss_pkg::DATA_W-1:0]  rd_data,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [rrss_pkg::DATA_W-1:0]  wr_data
);

  logic [rrss_pkg::DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

### design/round_robin_sleep_task_selector.sv
// Round-robin task selector with sleep. Each accepted start (start high, busy low)
// yields one result, shown for exactly one cycle while done is high; the receiver
// cannot stall it. A tick without a scheduling decision, or an unused op code,
// goes straight to the finishing state after acceptance. A decision adds the
// scheduling state plus a scan of the wake entries (at most the task count, clamped
// to MAX_TASKS, minus one), read one at a time from the wake-tick memory. A sleep
// first applies the millisecond scale, then launches the divide by TICK_US and
// waits on its reciprocal multiply (product, then add and shift) ahead of its decision.
// Wake ticks are cleared at reset by per-entry valid bits, so no clearing pass is
// needed. Depends on rrss_pkg, rrss_div, rrss_wake_mem and the assertion macro header.
`include "round_robin_sleep_task_selector_assert.svh"

module round_robin_sleep_task_selector #(
  parameter int MAX_TASKS = 16,
  parameter int TICK_US   = 10000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic [rrss_pkg::DATA_W-1:0]   sleep_amount,
  output logic                          done,
  output logic [3:0]                    running_task,
  output logic [3:0]                    rotation_position,
  output logic [rrss_pkg::DATA_W-1:0]   tick_now,
  output logic                          did_schedule,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_addr,
  input  logic [rrss_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int IW = $clog2(MAX_TASKS);

  rrss_pkg::state_t state, state_next;

  logic [1:0]                  op_q, op_q_next;
  logic [rrss_pkg::DATA_W-1:0] amount, amount_next;
  logic [rrss_pkg::DATA_W-1:0] counter, counter_next;
  logic [IW-1:0]               cur, cur_next;
  logic [IW-1:0]               ptr, ptr_next;
  logic [IW-1:0]               idx, idx_next;
  logic                        started, started_next;
  logic                        sched, sched_next;
  logic                        done_next;

  logic [rrss_pkg::CFG_W-1:0]  task_count;
  logic                        switch_on_tick;
  logic [rrss_pkg::CFG_W-1:0]  n_eff;
  logic [IW-1:0]               ptr_adv;
  logic [IW-1:0]               idx_inc;

  logic                        div_start;
  logic                        div_done;
  logic [rrss_pkg::DATA_W-1:0] quot;

  logic                        rd_en;
  logic [IW-1:0]               rd_addr;
  logic [rrss_pkg::DATA_W-1:0] rd_data;
  logic                        rd_hit;
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [rrss_pkg::DATA_W-1:0] wr_data;

  rrss_div #(
    .DIVISOR (TICK_US)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (amount),
    .quotient (quot),
    .done     (div_done)
  );

  rrss_wake_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count     <= rrss_pkg::CFG_W'(1);
      switch_on_tick <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        rrss_pkg::REG_TASK_COUNT:     task_count     <= cfg_wdata;
        rrss_pkg::REG_SWITCH_ON_TICK: switch_on_tick <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp the task count to the store depth.
  assign n_eff = (32'(task_count) > 32'(MAX_TASKS)) ? rrss_pkg::CFG_W'(MAX_TASKS)
                                                    : task_count;

  // Advance the pointer, wrapping to task 1.
  assign ptr_adv = (32'(ptr) >= 32'(n_eff) - 32'd1) ? IW'(1) : ptr + IW'(1);
  assign idx_inc = idx + IW'(1);

  // A zero wake tick also passes the compare.
  assign rd_hit = (rd_data == '0) || (rd_data <= counter);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rrss_pkg::ST_IDLE;
      counter <= '0;
      cur     <= '0;
      ptr     <= '0;
      idx     <= '0;
      started <= 1'b0;
      sched   <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      counter <= counter_next;
      cur     <= cur_next;
      ptr     <= ptr_next;
      idx     <= idx_next;
      started <= started_next;
      sched   <= sched_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q   <= op_q_next;
    amount <= amount_next;
  end

  always_comb begin
    state_next   = state;
    op_q_next    = op_q;
    amount_next  = amount;
    counter_next = counter;
    cur_next     = cur;
    ptr_next     = ptr;
    idx_next     = idx;
    started_next = started;
    sched_next   = sched;
    done_next    = 1'b0;
    div_start    = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = idx;
    wr_en        = 1'b0;
    wr_addr      = cur;
    wr_data      = '0;

    case (state)
      rrss_pkg::ST_IDLE: begin
        if (start) begin
          op_q_next   = op;
          amount_next = sleep_amount;
          sched_next  = 1'b0;
          case (op)
            rrss_pkg::OP_TICK: begin
              counter_next = counter + 32'd1;
              state_next   = switch_on_tick ? rrss_pkg::ST_SCHED : rrss_pkg::ST_FIN;
            end
            rrss_pkg::OP_SLEEP_US, rrss_pkg::OP_SLEEP_MS: begin
              state_next = rrss_pkg::ST_MUL;
            end
            default: begin
              state_next = rrss_pkg::ST_FIN;
            end
          endcase
        end
      end
      rrss_pkg::ST_MUL: begin
        if (op_q == rrss_pkg::OP_SLEEP_MS) begin
          amount_next = amount * rrss_pkg::US_PER_MS;
        end
        state_next = rrss_pkg::ST_DIV;
      end
      rrss_pkg::ST_DIV: begin
        div_start  = 1'b1;
        state_next = rrss_pkg::ST_WAIT;
      end
      rrss_pkg::ST_WAIT: begin
        if (div_done) begin
          wr_en      = 1'b1;
          wr_addr    = cur;
          wr_data    = counter + quot;
          state_next = rrss_pkg::ST_SCHED;
        end
      end
      rrss_pkg::ST_SCHED: begin
        if (!started) begin
          started_next = 1'b1;
          state_next   = rrss_pkg::ST_FIN;
        end else if (n_eff < rrss_pkg::CFG_W'(2)) begin
          ptr_next   = '0;
          cur_next   = '0;
          sched_next = 1'b1;
          state_next = rrss_pkg::ST_FIN;
        end else begin
          // Issue the first read; the scan starts at the advanced pointer.
          ptr_next   = ptr_adv;
          idx_next   = ptr_adv;
          cur_next   = '0;
          sched_next = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = ptr_adv;
          state_next = rrss_pkg::ST_CHECK;
        end
      end
      rrss_pkg::ST_CHECK: begin
        if (rd_hit) begin
          wr_en      = 1'b1;
          wr_addr    = idx;
          wr_data    = '0;
          cur_next   = idx;
          ptr_next   = idx;
          state_next = rrss_pkg::ST_FIN;
        end else if (32'(idx) + 32'd1 >= 32'(n_eff)) begin
          // No task ready: idle runs, pointer stays advanced.
          state_next = rrss_pkg::ST_FIN;
        end else begin
          idx_next = idx_inc;
          rd_en    = 1'b1;
          rd_addr  = idx_inc;
        end
      end
      rrss_pkg::ST_FIN: begin
        done_next  = 1'b1;
        state_next = rrss_pkg::ST_IDLE;
      end
      default: begin
        state_next = rrss_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy              = (state != rrss_pkg::ST_IDLE);
  assign running_task      = 4'(cur);
  assign rotation_position = 4'(ptr);
  assign tick_now          = counter;
  assign did_schedule      = sched;

  `RRSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `RRSS_ASSERT_NOW(a_done_after_work, done, $past(busy))
  `RRSS_ASSERT_NOW(a_sched_needs_start, done && did_schedule, started)
  `RRSS_ASSERT_NOW(a_run_at_pointer, done && did_schedule && running_task != 4'd0, running_task == rotation_position)

endmodule

### tb/tb_top.sv
// Self-checking testbench for round_robin_sleep_task_selector: tick and sleep events
// go in through the start/busy handshake and each strobed result is scored in order.
// Depends on rrss_pkg and the selector RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TASK_SLOTS     = 16;
  localparam int unsigned TICK_PERIOD_US = 10000;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int          PHASES         = 10;
  localparam int          PHASE_EVENTS   = 50;

  typedef struct {
    logic [3:0]  running;
    logic [3:0]  pointer;
    logic [31:0] ticks;
    logic        scheduled;
  } pick_t;

  class task_pick_scoreboard;
    logic [31:0] tick_count;
    logic [31:0] wake_at [TASK_SLOTS];
    logic [3:0]  rr_ptr;
    logic [3:0]  cur_task;
    bit          started;
    logic [4:0]  task_count;
    bit          switch_on_tick;
    pick_t       pick_queue[$];
    int          errors;

    function new();
      foreach (wake_at[i]) wake_at[i] = '0;
      tick_count     = '0;
      rr_ptr         = '0;
      cur_task       = '0;
      started        = 0;
      task_count     = 5'd1;
      switch_on_tick = 1;
      errors         = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [4:0] val);
      if (idx == rrss_pkg::REG_TASK_COUNT) task_count = val;
      else switch_on_tick = val[0];
    endfunction

    function int pending();
      return pick_queue.size();
    endfunction

    // The first decision only arms the scheduler; the scan never wraps past the top.
    function bit pick_next_task();
      int unsigned n;
      if (!started) begin
        started = 1;
        return 0;
      end
      n = (task_count > TASK_SLOTS) ? TASK_SLOTS : task_count;
      if (n < 2) begin
        rr_ptr   = '0;
        cur_task = '0;
        return 1;
      end
      if (rr_ptr >= n - 1) rr_ptr = 4'd1;
      else rr_ptr = rr_ptr + 4'd1;
      cur_task = '0;
      for (int i = rr_ptr; i < n; i++) begin
        if (wake_at[i] == 0 || wake_at[i] <= tick_count) begin
          wake_at[i] = '0;
          cur_task   = i[3:0];
          rr_ptr     = i[3:0];
          return 1;
        end
      end
      return 1;
    endfunction

    function void note_event(logic [1:0] kind, logic [31:0] amount);
      logic [31:0] us;
      pick_t       p;
      bit          sched;
      sched = 0;
      case (kind)
        rrss_pkg::OP_TICK: begin
          tick_count = tick_count + 32'd1;
          if (switch_on_tick) sched = pick_next_task();
        end
        rrss_pkg::OP_SLEEP_US, rrss_pkg::OP_SLEEP_MS: begin
          us = (kind == rrss_pkg::OP_SLEEP_MS) ? amount * rrss_pkg::US_PER_MS : amount;
          wake_at[cur_task] = tick_count + us / TICK_PERIOD_US;
          sched = pick_next_task();
        end
        default: sched = 0;
      endcase
      p.running   = cur_task;
      p.pointer   = rr_ptr;
      p.ticks     = tick_count;
      p.scheduled = sched;
      pick_queue.push_back(p);
    endfunction

    function void check_result(logic [3:0] running, logic [3:0] pointer,
                               logic [31:0] ticks, logic scheduled);
      pick_t p;
      if (pick_queue.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      p = pick_queue.pop_front();
      if (running !== p.running) begin
        $error("running_task expected %0d got %0d", p.running, running);
        errors++;
      end
      if (pointer !== p.pointer) begin
        $error("rotation_position expected %0d got %0d", p.pointer, pointer);
        errors++;
      end
      if (ticks !== p.ticks) begin
        $error("tick_now expected %0d got %0d", p.ticks, ticks);
        errors++;
      end
      if (scheduled !== p.scheduled) begin
        $error("did_schedule expected %0d got %0d", p.scheduled, scheduled);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [31:0] sleep_amount;
  logic        done;
  logic [3:0]  running_task;
  logic [3:0]  rotation_position;
  logic [31:0] tick_now;
  logic        did_schedule;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [4:0]  cfg_wdata;

  task_pick_scoreboard sb;
  bit allow_gaps;

  round_robin_sleep_task_selector #(
    .MAX_TASKS(TASK_SLOTS),
    .TICK_US  (TICK_PERIOD_US)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .op               (op),
    .sleep_amount     (sleep_amount),
    .done             (done),
    .running_task     (running_task),
    .rotation_position(rotation_position),
    .tick_now         (tick_now),
    .did_schedule     (did_schedule),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL round_robin_sleep_task_selector");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(running_task, rotation_position, tick_now, did_schedule);
  end

  task automatic post_event(input logic [1:0] kind, input logic [31:0] amount);
    int gap;
    if (allow_gaps && $urandom_range(99) < 29) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      @(negedge clk);
      start        = 0;
      op           = 2'($urandom);
      sleep_amount = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        = 1;
    op           = kind;
    sleep_amount = amount;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_event(kind, amount);
  endtask

  // Drop start and hold until every transaction has produced its result.
  task automatic drain();
    @(negedge clk);
    start = 0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_reg(input logic [0:0] idx, input logic [4:0] val);
    drain();
    @(negedge clk);
    cfg_we    = 1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_event();
    int          r;
    logic [31:0] amount;
    r = $urandom_range(99);
    if (r < 50) begin
      post_event(rrss_pkg::OP_TICK, $urandom);
    end else if (r < 72) begin
      amount = ($urandom_range(9) == 0) ? $urandom : $urandom_range(120000);
      post_event(rrss_pkg::OP_SLEEP_US, amount);
    end else if (r < 92) begin
      amount = ($urandom_range(9) == 0) ? $urandom : $urandom_range(150);
      post_event(rrss_pkg::OP_SLEEP_MS, amount);
    end else begin
      post_event(OP_UNUSED, $urandom);
    end
  endtask

  initial begin
    logic [4:0] counts [9];
    logic [4:0] cnt;
    counts       = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd16, 5'd17, 5'd31};
    sb           = new();
    allow_gaps   = 1;
    rst          = 1;
    start        = 0;
    op           = rrss_pkg::OP_TICK;
    sleep_amount = '0;
    cfg_we       = 0;
    cfg_addr     = rrss_pkg::REG_TASK_COUNT;
    cfg_wdata    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // First decision only arms the scheduler, then idle alone.
    post_event(rrss_pkg::OP_TICK, 32'd0);
    post_event(rrss_pkg::OP_SLEEP_US, 32'd0);
    set_reg(rrss_pkg::REG_TASK_COUNT, 5'd0);
    post_event(rrss_pkg::OP_TICK, 32'hFFFF_FFFF);

    set_reg(rrss_pkg::REG_TASK_COUNT, 5'd4);
    post_event(rrss_pkg::OP_TICK, 32'd0);
    post_event(rrss_pkg::OP_TICK, 32'd0);
    post_event(rrss_pkg::OP_SLEEP_US, 32'hFFFF_FFFF);
    post_event(rrss_pkg::OP_SLEEP_MS, 32'hFFFF_FFFF);
    post_event(rrss_pkg::OP_SLEEP_MS, 32'd0);
    post_event(rrss_pkg::OP_SLEEP_US, 32'd25000);
    post_event(OP_UNUSED, 32'hA5A5_5A5A);
    post_event(rrss_pkg::OP_TICK, 32'd0);
    post_event(rrss_pkg::OP_TICK, 32'd0);
    post_event(rrss_pkg::OP_TICK, 32'd0);

    // Count above the task limit clamps.
    set_reg(rrss_pkg::REG_TASK_COUNT, 5'd31);
    post_event(rrss_pkg::OP_TICK, 32'd0);
    post_event(rrss_pkg::OP_TICK, 32'd0);
    post_event(rrss_pkg::OP_SLEEP_MS, 32'd5);

    set_reg(rrss_pkg::REG_SWITCH_ON_TICK, 5'd0);
    post_event(rrss_pkg::OP_TICK, 32'd0);
    post_event(rrss_pkg::OP_TICK, 32'd0);
    post_event(rrss_pkg::OP_SLEEP_US, 32'd10000);

    set_reg(rrss_pkg::REG_SWITCH_ON_TICK, 5'd1);
    set_reg(rrss_pkg::REG_TASK_COUNT, 5'd16);
    repeat (3) post_event(rrss_pkg::OP_TICK, 32'd0);
    // Pointer now sits beyond a lowered count.
    set_reg(rrss_pkg::REG_TASK_COUNT, 5'd2);
    post_event(rrss_pkg::OP_TICK, 32'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      cnt = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : counts[$urandom_range(8)];
      set_reg(rrss_pkg::REG_TASK_COUNT, cnt);
      set_reg(rrss_pkg::REG_SWITCH_ON_TICK, ($urandom_range(4) == 0) ? 5'd0 : 5'd1);
      allow_gaps = (ph != 4);
      repeat (PHASE_EVENTS) random_event();
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("PASS round_robin_sleep_task_selector");
    else $display("FAIL round_robin_sleep_task_selector");
    $finish;
  end

endmodule
